// ----- rtl/core/odfs_pkg.sv -----
package odfs_pkg;

	localparam int MaxItems = 16;
	localparam int ValueW   = 32;

	typedef logic signed [ValueW-1:0] value_t;

	// Per-cycle command broadcast to every cell of the sorting chain.
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_FILL  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

// ----- rtl/core/odfs_if.sv -----
interface odfs_item_if;
	logic                  valid;
	logic                  ready;
	odfs_pkg::value_t      item_value;
	logic                  item_last;

	modport source (output valid, item_value, item_last, input ready);
	modport sink   (input valid, item_value, item_last, output ready);
endinterface

interface odfs_result_if;
	logic                  valid;
	logic                  ready;
	odfs_pkg::value_t      sorted_value;
	logic                  run_last;
	logic                  run_empty;
	logic                  overflowed;

	modport source (output valid, sorted_value, run_last, run_empty, overflowed, input ready);
	modport sink   (input valid, sorted_value, run_last, run_empty, overflowed, output ready);
endinterface

// ----- rtl/core/odfs_cell.sv -----
module odfs_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  odfs_pkg::cell_ctrl_t   ctrl,
	input  odfs_pkg::value_t       new_value,
	input  odfs_pkg::value_t       prev_value,
	input  logic                   prev_valid,
	input  logic                   prev_gt,
	input  odfs_pkg::value_t       next_value,
	input  logic                   next_valid,
	output odfs_pkg::value_t       value,
	output logic                   valid,
	output logic                   gt
);

	odfs_pkg::value_t value_q;
	logic             valid_q;

	// An empty cell, or one holding a strictly smaller value, yields to the new value.
	assign gt    = !valid_q || (value_q < new_value);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_value;
		end else if (ctrl.insert && gt) begin
			value_q <= prev_gt ? prev_value : new_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && gt) begin
			valid_q <= prev_gt ? prev_valid : 1'b1;
		end
	end

endmodule

// ----- rtl/core/odd_filter_descending_sort_top.sv -----
// Channel  | Dir | Payload                                          | Role
// item_ch  | in  | item_value[31:0] signed, item_last               | one integer of the set
// result_ch| out | sorted_value[31:0] signed, run_last, run_empty,   | kept odd values,
//          |     | overflowed                                       | largest first
//
// Fill: one item per cycle; every cell of the 16-cell chain compares against the
// incoming value in parallel and the chain shifts open a slot in the same cycle.
// Drain: after the last item, one result per cycle while result_ch.ready is high (N kept
// values, or one empty result) shifted out of the head cell; item_ch.ready is low for
// the whole drain.
// Reset clears all cell valid bits and the overflow flag; output stalls simply hold the chain.
module odd_filter_descending_sort_top (
	input logic           clk,
	input logic           arst_n,
	odfs_item_if.sink     item_ch,
	odfs_result_if.source result_ch
);

	odfs_pkg::state_t        state_q;
	logic                    overflow_q;
	odfs_pkg::cell_ctrl_t    ctrl;
	odfs_pkg::value_t        cell_value [odfs_pkg::MaxItems];
	logic [odfs_pkg::MaxItems-1:0] cell_valid;
	logic [odfs_pkg::MaxItems-1:0] cell_gt;
	logic                    item_acc;
	logic                    result_acc;
	logic                    is_odd;
	logic                    full;

	assign item_acc   = item_ch.valid && item_ch.ready;
	assign result_acc = result_ch.valid && result_ch.ready;
	assign is_odd     = item_ch.item_value[0];
	assign full       = cell_valid[odfs_pkg::MaxItems-1];

	assign ctrl.insert = item_acc && is_odd && !full;
	assign ctrl.shift  = result_acc;

	genvar g;
	generate
		for (g = 0; g < odfs_pkg::MaxItems; g++) begin : g_cell
			odfs_pkg::value_t prev_value;
			logic             prev_valid;
			logic             prev_gt;
			odfs_pkg::value_t next_value;
			logic             next_valid;

			if (g == 0) begin : g_head
				assign prev_value = item_ch.item_value;
				assign prev_valid = 1'b0;
				assign prev_gt    = 1'b0;
			end else begin : g_body
				assign prev_value = cell_value[g-1];
				assign prev_valid = cell_valid[g-1];
				assign prev_gt    = cell_gt[g-1];
			end

			if (g == odfs_pkg::MaxItems - 1) begin : g_tail
				assign next_value = cell_value[g];
				assign next_valid = 1'b0;
			end else begin : g_mid
				assign next_value = cell_value[g+1];
				assign next_valid = cell_valid[g+1];
			end

			odfs_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.new_value  (item_ch.item_value),
				.prev_value (prev_value),
				.prev_valid (prev_valid),
				.prev_gt    (prev_gt),
				.next_value (next_value),
				.next_valid (next_valid),
				.value      (cell_value[g]),
				.valid      (cell_valid[g]),
				.gt         (cell_gt[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= odfs_pkg::ST_FILL;
			overflow_q <= 1'b0;
		end else begin
			case (state_q)
				odfs_pkg::ST_FILL: begin
					if (item_acc && is_odd && full) begin
						overflow_q <= 1'b1;
					end
					if (item_acc && item_ch.item_last) begin
						state_q <= odfs_pkg::ST_DRAIN;
					end
				end
				odfs_pkg::ST_DRAIN: begin
					if (result_acc && result_ch.run_last) begin
						state_q    <= odfs_pkg::ST_FILL;
						overflow_q <= 1'b0;
					end
				end
				default: begin
					state_q <= odfs_pkg::ST_FILL;
				end
			endcase
		end
	end

	assign item_ch.ready          = (state_q == odfs_pkg::ST_FILL);
	assign result_ch.valid        = (state_q == odfs_pkg::ST_DRAIN);
	assign result_ch.sorted_value = cell_valid[0] ? cell_value[0] : '0;
	assign result_ch.run_empty    = !cell_valid[0];
	assign result_ch.run_last     = !cell_valid[1];
	assign result_ch.overflowed   = overflow_q;

	// Occupied cells always form a prefix of the chain.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + {{(odfs_pkg::MaxItems-1){1'b0}}, 1'b1})) == '0)
		else $error("cell valid bits are not contiguous from the head");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ch.ready && result_ch.valid))
		else $error("input taken while results are pending");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.run_empty |-> result_ch.run_last)
		else $error("empty result not marked last");

	a_run_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result_acc && result_ch.run_last |=> item_ch.ready && !overflow_q && !cell_valid[0])
		else $error("state not cleared after the final result");

endmodule
